// ===== design/ile_pkg.sv =====
package ile_pkg;

    localparam int OP_W  = 4;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int FIL_W = 7;
    localparam int LEN_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND       = 4'd0,
        OP_POP_BACK     = 4'd1,
        OP_POP_FRONT    = 4'd2,
        OP_INSERT       = 4'd3,
        OP_ERASE        = 4'd4,
        OP_READ_AT      = 4'd5,
        OP_FRONT        = 4'd6,
        OP_BACK         = 4'd7,
        OP_CLEAR        = 4'd8,
        OP_RESIZE       = 4'd9,
        OP_ASSIGN       = 4'd10,
        OP_REMOVE_VALUE = 4'd11
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY_FULL = 2'd1,
        ST_RANGE      = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // Per-cell update action, broadcast along the row.
    typedef enum logic [2:0] {
        CA_HOLD,
        CA_WRITE_AT,
        CA_INSERT,
        CA_PULL_FROM,
        CA_PULL_FOUND,
        CA_FILL
    } t_cell_act;

    typedef struct packed {
        t_cell_act act;
        logic      by_value;
    } t_cell_ctl;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] element_value;
        logic [FIL_W-1:0] fill_count;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] read_data;
        logic [LEN_W-1:0] length;
    } t_resp;

endpackage

// ===== design/indexed_list_engine_unit.sv =====
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------
// request   | start in, busy out      | i_req  (t_req)
// result    | o_valid out, no stall   | o_resp (t_resp)
//
// Accepted at an edge with start high and busy low; the result beat shows
// for one cycle on o_valid, in the cycle after the last busy cycle.
// Update ops (push, pop back, insert, erase, clear, resize, assign, unknown
// codes) keep busy high only in the apply state, and no request is taken then.
// Read and search ops (pop front, read_at, front, back, remove_value) keep
// busy high through the scan state, while the scan wave walks the cell row
// one cell per cycle, and then the apply state; no request is taken meanwhile.
// Reset clears the length only; the element cells are not cleared.
// The receiver cannot stall: the next request is taken while o_valid shows.
module indexed_list_engine_unit
    import ile_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int ELEM_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_valid,
    output t_resp o_resp
);

    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int CW     = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int SCAN_W = $clog2(CAPACITY);
    localparam int XW     = ELEM_BITS + VAL_W;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(CAPACITY - 1);
    localparam logic [CW-1:0]     CAP_X     = CW'(CAPACITY);

    t_state             r_state;
    t_state             n_state;
    logic [SCAN_W-1:0]  r_scan;
    logic [SCAN_W-1:0]  n_scan;
    logic [IDX_W-1:0]   r_count;
    logic [IDX_W-1:0]   n_count;
    t_req               r_req;
    logic               r_done;
    t_resp              r_resp;
    t_resp              n_resp;

    logic               accept;
    logic               need_scan;
    logic               exec_en;
    logic               scan_en;

    t_cell_act          dec_act;
    t_cell_ctl          cell_ctl;
    logic [IDX_W-1:0]   bc_lo;
    logic [IDX_W-1:0]   bc_hi;
    logic [ELEM_BITS-1:0] bc_val;

    logic [CW-1:0]      pos_x;
    logic [CW-1:0]      fil_x;
    logic [CW-1:0]      cnt_x;
    logic [CW-1:0]      len_x;
    logic [XW-1:0]      val_x;
    logic [XW-1:0]      rd_x;
    logic [ELEM_BITS-1:0] val_e;
    logic               empty;
    logic               full;

    logic [ELEM_BITS-1:0] cell_data [CAPACITY];
    logic                 found_chain [CAPACITY+1];
    logic [ELEM_BITS-1:0] wdata_chain [CAPACITY+1];

    assign accept = start && !busy;

    always_comb begin
        unique case (t_op'(i_req.op))
            OP_POP_FRONT, OP_READ_AT, OP_FRONT, OP_BACK, OP_REMOVE_VALUE:
                need_scan = 1'b1;
            default: need_scan = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = need_scan ? S_SCAN : S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN:  n_state = (r_scan == SCAN_LAST) ? S_EXEC : S_SCAN;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                busy    = 1'b0;
                scan_en = 1'b0;
                exec_en = 1'b0;
            end
            S_SCAN: begin
                busy    = 1'b1;
                scan_en = 1'b1;
                exec_en = 1'b0;
            end
            S_EXEC: begin
                busy    = 1'b1;
                scan_en = 1'b0;
                exec_en = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                scan_en = 1'b0;
                exec_en = 1'b0;
            end
        endcase
    end

    assign n_scan = scan_en ? (r_scan + SCAN_W'(1)) : '0;

    assign pos_x = CW'(r_req.position);
    assign fil_x = CW'(r_req.fill_count);
    assign cnt_x = CW'(r_count);
    assign val_x = XW'(r_req.element_value);
    assign val_e = val_x[ELEM_BITS-1:0];
    assign empty = (r_count == '0);
    assign full  = (cnt_x == CAP_X);
    assign rd_x  = XW'(wdata_chain[CAPACITY]);

    // Decode the held request against the current length.
    always_comb begin
        dec_act          = CA_HOLD;
        bc_lo            = '0;
        bc_hi            = r_count;
        bc_val           = val_e;
        n_count          = r_count;
        n_resp.status    = ST_OK;
        n_resp.read_data = '0;
        unique case (t_op'(r_req.op))
            OP_APPEND: begin
                bc_lo = r_count;
                if (full) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    dec_act = CA_WRITE_AT;
                    n_count = r_count + IDX_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    n_count = r_count - IDX_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    dec_act          = CA_PULL_FROM;
                    n_count          = r_count - IDX_W'(1);
                    n_resp.read_data = rd_x[VAL_W-1:0];
                end
            end
            OP_INSERT: begin
                bc_lo = pos_x[IDX_W-1:0];
                if (pos_x > cnt_x) begin
                    n_resp.status = ST_RANGE;
                end else if (full) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    dec_act = CA_INSERT;
                    n_count = r_count + IDX_W'(1);
                end
            end
            OP_ERASE: begin
                bc_lo = pos_x[IDX_W-1:0];
                if (pos_x >= cnt_x) begin
                    n_resp.status = ST_RANGE;
                end else begin
                    dec_act = CA_PULL_FROM;
                    n_count = r_count - IDX_W'(1);
                end
            end
            OP_READ_AT: begin
                bc_lo = pos_x[IDX_W-1:0];
                if (pos_x >= cnt_x) begin
                    n_resp.status = ST_RANGE;
                end else begin
                    n_resp.read_data = rd_x[VAL_W-1:0];
                end
            end
            OP_FRONT: begin
                if (empty) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    n_resp.read_data = rd_x[VAL_W-1:0];
                end
            end
            OP_BACK: begin
                bc_lo = r_count - IDX_W'(1);
                if (empty) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    n_resp.read_data = rd_x[VAL_W-1:0];
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_RESIZE: begin
                bc_lo  = r_count;
                bc_hi  = fil_x[IDX_W-1:0];
                bc_val = '0;
                if (fil_x > CAP_X) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    dec_act = CA_FILL;
                    n_count = fil_x[IDX_W-1:0];
                end
            end
            OP_ASSIGN: begin
                bc_hi = fil_x[IDX_W-1:0];
                if (fil_x > CAP_X) begin
                    n_resp.status = ST_EMPTY_FULL;
                end else begin
                    dec_act = CA_FILL;
                    n_count = fil_x[IDX_W-1:0];
                end
            end
            OP_REMOVE_VALUE: begin
                if (found_chain[CAPACITY]) begin
                    dec_act = CA_PULL_FOUND;
                    n_count = r_count - IDX_W'(1);
                end else begin
                    n_resp.status = ST_NOT_FOUND;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        len_x         = CW'(n_count);
        n_resp.length = len_x[LEN_W-1:0];
    end

    // Hold the cells unless the request is being applied.
    assign cell_ctl.act      = exec_en ? dec_act : CA_HOLD;
    assign cell_ctl.by_value = (t_op'(r_req.op) == OP_REMOVE_VALUE);

    assign found_chain[0] = 1'b0;
    assign wdata_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_BITS-1:0] left;
        logic [ELEM_BITS-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner_r
            assign right = cell_data[g+1];
        end

        ile_cell #(
            .ELEM_BITS (ELEM_BITS),
            .IDX_W     (IDX_W),
            .INDEX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_lo    (bc_lo),
            .i_hi    (bc_hi),
            .i_val   (bc_val),
            .i_left  (left),
            .i_right (right),
            .i_found (found_chain[g]),
            .i_wdata (wdata_chain[g]),
            .o_data  (cell_data[g]),
            .o_found (found_chain[g+1]),
            .o_wdata (wdata_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scan  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_done  <= exec_en;
            if (exec_en) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (exec_en) begin
            r_resp <= n_resp;
        end
    end

    assign o_valid = r_done;
    assign o_resp  = r_resp;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= CAP_X)
        else $error("length above capacity");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> o_valid && r_state == S_IDLE)
        else $error("result beat missing after apply cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request accepted without going busy");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && r_scan == SCAN_LAST |=> r_state == S_EXEC)
        else $error("scan wave did not end in apply cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat shown while busy");

endmodule

// ===== design/ile_cell.sv =====
module ile_cell
    import ile_pkg::*;
#(
    parameter int ELEM_BITS = 32,
    parameter int IDX_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]     i_lo,
    input  logic [IDX_W-1:0]     i_hi,
    input  logic [ELEM_BITS-1:0] i_val,
    input  logic [ELEM_BITS-1:0] i_left,
    input  logic [ELEM_BITS-1:0] i_right,
    input  logic                 i_found,
    input  logic [ELEM_BITS-1:0] i_wdata,
    output logic [ELEM_BITS-1:0] o_data,
    output logic                 o_found,
    output logic [ELEM_BITS-1:0] o_wdata
);

    localparam logic [IDX_W-1:0] IDX = INDEX[IDX_W-1:0];

    logic [ELEM_BITS-1:0] r_data;
    logic [ELEM_BITS-1:0] n_data;
    logic                 r_found;
    logic                 n_found;
    logic [ELEM_BITS-1:0] r_wdata;
    logic [ELEM_BITS-1:0] n_wdata;
    logic                 hit;

    // Scan wave: the first hit along the row claims the beat.
    always_comb begin
        if (i_ctl.by_value) begin
            hit = (r_data == i_val) && (IDX < i_hi);
        end else begin
            hit = (IDX == i_lo);
        end
        n_found = i_found | hit;
        n_wdata = (hit && !i_found) ? r_data : i_wdata;
    end

    always_comb begin
        unique case (i_ctl.act)
            CA_HOLD:       n_data = r_data;
            CA_WRITE_AT:   n_data = (IDX == i_lo) ? i_val : r_data;
            CA_INSERT: begin
                if (IDX == i_lo) begin
                    n_data = i_val;
                end else if (IDX > i_lo) begin
                    n_data = i_left;
                end else begin
                    n_data = r_data;
                end
            end
            CA_PULL_FROM:  n_data = (IDX >= i_lo) ? i_right : r_data;
            CA_PULL_FOUND: n_data = r_found ? i_right : r_data;
            CA_FILL:       n_data = (IDX >= i_lo && IDX < i_hi) ? i_val : r_data;
            default:       n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_found <= n_found;
        r_wdata <= n_wdata;
    end

    assign o_data  = r_data;
    assign o_found = r_found;
    assign o_wdata = r_wdata;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ile_pkg::*;

    localparam int LIST_CAP       = 64;
    localparam int QUIET_MAX      = 2000;
    localparam int RAND_ITEMS     = 1025;
    localparam int OP_SPARE_FIRST = 12;
    localparam int OP_SPARE_LAST  = 15;

    typedef struct {
        t_req        req;
        int unsigned gap;
    } t_req_slot;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  req_bus = '0;
    logic  o_valid;
    t_resp o_resp;

    t_req_slot        pending_reqs[$];
    t_resp            resp_due[$];
    logic [VAL_W-1:0] model_cells [LIST_CAP];
    int unsigned      model_len    = 0;
    t_req_slot        staged_slot;
    bit               slot_staged  = 1'b0;
    int unsigned      slot_wait    = 0;
    bit               req_taken    = 1'b0;
    bit               no_gaps      = 1'b0;
    int unsigned      quiet_cycles = 0;
    int unsigned      fail_count   = 0;

    indexed_list_engine_unit #(
        .CAPACITY (LIST_CAP),
        .ELEM_BITS(VAL_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (req_bus),
        .o_valid(o_valid),
        .o_resp (o_resp)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Close the hole left at index at by shifting the tail down.
    function automatic void drop_cell(input int unsigned at);
        int unsigned k;
        for (k = at; k + 1 < model_len; k++) begin
            model_cells[k] = model_cells[k + 1];
        end
        model_len--;
    endfunction

    function automatic t_resp list_apply(input t_req r);
        t_resp       res;
        int unsigned k;
        int unsigned hit;
        res.status    = ST_OK;
        res.read_data = '0;
        case (r.op)
            OP_APPEND: begin
                if (model_len >= LIST_CAP) begin
                    res.status = ST_EMPTY_FULL;
                end else begin
                    model_cells[model_len] = r.element_value;
                    model_len++;
                end
            end
            OP_POP_BACK: begin
                if (model_len == 0) res.status = ST_EMPTY_FULL;
                else model_len--;
            end
            OP_POP_FRONT: begin
                if (model_len == 0) begin
                    res.status = ST_EMPTY_FULL;
                end else begin
                    res.read_data = model_cells[0];
                    drop_cell(0);
                end
            end
            OP_INSERT: begin
                // range test wins over the full test
                if (r.position > model_len) begin
                    res.status = ST_RANGE;
                end else if (model_len >= LIST_CAP) begin
                    res.status = ST_EMPTY_FULL;
                end else begin
                    for (k = model_len; k > r.position; k--) begin
                        model_cells[k] = model_cells[k - 1];
                    end
                    model_cells[r.position] = r.element_value;
                    model_len++;
                end
            end
            OP_ERASE: begin
                if (r.position >= model_len) res.status = ST_RANGE;
                else drop_cell(r.position);
            end
            OP_READ_AT: begin
                if (r.position >= model_len) res.status = ST_RANGE;
                else res.read_data = model_cells[r.position];
            end
            OP_FRONT: begin
                if (model_len == 0) res.status = ST_EMPTY_FULL;
                else res.read_data = model_cells[0];
            end
            OP_BACK: begin
                if (model_len == 0) res.status = ST_EMPTY_FULL;
                else res.read_data = model_cells[model_len - 1];
            end
            OP_CLEAR: begin
                model_len = 0;
            end
            OP_RESIZE: begin
                if (r.fill_count > LIST_CAP) begin
                    res.status = ST_EMPTY_FULL;
                end else begin
                    for (k = model_len; k < r.fill_count; k++) begin
                        model_cells[k] = '0;
                    end
                    model_len = r.fill_count;
                end
            end
            OP_ASSIGN: begin
                if (r.fill_count > LIST_CAP) begin
                    res.status = ST_EMPTY_FULL;
                end else begin
                    for (k = 0; k < r.fill_count; k++) begin
                        model_cells[k] = r.element_value;
                    end
                    model_len = r.fill_count;
                end
            end
            OP_REMOVE_VALUE: begin
                hit = model_len;
                for (k = 0; k < model_len && hit == model_len; k++) begin
                    if (model_cells[k] == r.element_value) hit = k;
                end
                if (hit < model_len) drop_cell(hit);
                else res.status = ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(model_len);
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] rand_elem();
        int unsigned r;
        r = $urandom_range(0, 99);
        // keep most values in a small pool so that removes find matches
        if (r < 50) return VAL_W'($urandom_range(0, 7));
        if (r < 60) return '1;
        if (r < 65) return '0;
        return $urandom;
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] op, input int unsigned pos,
                             input logic [VAL_W-1:0] val, input int unsigned cnt);
        t_req_slot s;
        s.req.op            = op;
        s.req.position      = POS_W'(pos);
        s.req.element_value = val;
        s.req.fill_count    = FIL_W'(cnt);
        s.gap               = no_gaps ? 0 : $urandom_range(0, 4);
        pending_reqs.insert(pending_reqs.size(), s);
    endtask

    // Driver: hold a beat until taken, then idle for the next beat's gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (!slot_staged && pending_reqs.size() != 0) begin
                staged_slot = pending_reqs.pop_front();
                slot_staged = 1'b1;
                slot_wait   = staged_slot.gap;
            end
            if (slot_staged && slot_wait == 0) begin
                req_bus     <= staged_slot.req;
                start       <= 1'b1;
                slot_staged = 1'b0;
            end else begin
                start <= 1'b0;
                if (slot_staged) slot_wait--;
            end
        end
    end

    // Monitor: check result beats, predict on every accepted request.
    always @(posedge i_clk) begin : monitor
        t_resp want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                if (resp_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end else begin
                    want = resp_due.pop_front();
                    if (o_resp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                               o_resp.status);
                        fail_count++;
                    end
                    if (o_resp.read_data !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data,
                               o_resp.read_data);
                        fail_count++;
                    end
                    if (o_resp.length !== want.length) begin
                        $error("length: expected %0d, actual %0d", want.length,
                               o_resp.length);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                req_taken = 1'b1;
                resp_due.insert(resp_due.size(), list_apply(req_bus));
            end
            if (o_valid || req_taken) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned      i;
        int unsigned      sel;
        int unsigned      pos;
        int unsigned      cnt;
        logic [OP_W-1:0]  op;

        // empty list corner cases
        queue_req(OP_POP_BACK, 0, '0, 0);
        queue_req(OP_POP_FRONT, 0, '0, 0);
        queue_req(OP_FRONT, 0, '0, 0);
        queue_req(OP_BACK, 0, '0, 0);
        queue_req(OP_ERASE, 0, '0, 0);
        queue_req(OP_READ_AT, 0, '0, 0);
        queue_req(OP_REMOVE_VALUE, 0, '0, 0);
        queue_req(OP_INSERT, 1, 32'h1111_1111, 0);
        // small list, shifts both ways
        queue_req(OP_INSERT, 0, 32'hFFFF_FFFF, 0);
        queue_req(OP_APPEND, 0, 32'h0000_0000, 0);
        queue_req(OP_APPEND, 0, 32'hA5A5_A5A5, 0);
        queue_req(OP_INSERT, 1, 32'h5A5A_5A5A, 0);
        queue_req(OP_READ_AT, 127, '0, 0);
        queue_req(OP_READ_AT, 2, '0, 0);
        queue_req(OP_ERASE, 1, '0, 0);
        queue_req(OP_FRONT, 0, '0, 0);
        queue_req(OP_BACK, 0, '0, 0);
        queue_req(OP_POP_FRONT, 0, '0, 0);
        queue_req(OP_REMOVE_VALUE, 0, 32'hA5A5_A5A5, 0);
        // full list and oversize counts
        queue_req(OP_RESIZE, 0, '0, LIST_CAP);
        queue_req(OP_APPEND, 0, 32'h7777_7777, 0);
        queue_req(OP_INSERT, LIST_CAP, 32'h7777_7777, 0);
        queue_req(OP_INSERT, LIST_CAP + 1, 32'h7777_7777, 0);
        queue_req(OP_RESIZE, 0, '0, LIST_CAP + 1);
        queue_req(OP_ASSIGN, 0, 32'h1234_5678, 127);
        queue_req(OP_ASSIGN, 0, 32'h1234_5678, LIST_CAP);
        queue_req(OP_POP_BACK, 0, '0, 0);
        queue_req(OP_W'(OP_SPARE_LAST), 127, '1, 127);
        queue_req(OP_CLEAR, 0, '0, 0);

        for (i = 0; i < RAND_ITEMS; i++) begin
            // alternate stretches with and without idle gaps
            no_gaps = ((i / 40) % 3) == 0;
            sel = $urandom_range(0, 99);
            if (sel < 18) op = OP_APPEND;
            else if (sel < 24) op = OP_POP_BACK;
            else if (sel < 30) op = OP_POP_FRONT;
            else if (sel < 44) op = OP_INSERT;
            else if (sel < 52) op = OP_ERASE;
            else if (sel < 62) op = OP_READ_AT;
            else if (sel < 66) op = OP_FRONT;
            else if (sel < 70) op = OP_BACK;
            else if (sel < 72) op = OP_CLEAR;
            else if (sel < 78) op = OP_RESIZE;
            else if (sel < 84) op = OP_ASSIGN;
            else if (sel < 97) op = OP_REMOVE_VALUE;
            else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            sel = $urandom_range(0, 99);
            if (sel < 60) pos = $urandom_range(0, 15);
            else if (sel < 90) pos = $urandom_range(0, LIST_CAP);
            else pos = $urandom_range(0, 127);
            sel = $urandom_range(0, 99);
            if (sel < 65) cnt = $urandom_range(0, 16);
            else if (sel < 80) cnt = $urandom_range(0, LIST_CAP);
            else if (sel < 88) cnt = LIST_CAP;
            else cnt = $urandom_range(LIST_CAP + 1, 127);
            queue_req(op, pos, rand_elem(), cnt);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || slot_staged || start || resp_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LIST_CAP + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
